FILE: rtl/power_switch_manager_core_macros.svh
// Assertion macros for the power switch manager.
`ifndef POWER_SWITCH_MANAGER_CORE_MACROS_SVH
`define POWER_SWITCH_MANAGER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// Clocked check, disabled while reset is asserted.
`define PSM_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("power switch manager check failed");
// Clocked check that also holds across reset.
`define PSM_ASSERT_ANY(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("power switch manager reset check failed");
`else
`define PSM_ASSERT(name, prop)
`define PSM_ASSERT_ANY(name, prop)
`endif

`endif

FILE: rtl/psm_pkg.sv
// Shared types and constants of the power switch manager.
`timescale 1ns / 1ps
package psm_pkg;

  localparam int PINS    = 16;
  localparam int CELL_W  = $clog2(PINS);
  localparam int WORD_W  = 16;
  localparam int PIN_W   = 4;
  localparam int MS_W    = 16;
  localparam int CNT_W   = 8;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [2:0] {
    FN_TICK    = 3'd0,
    FN_SET     = 3'd1,
    FN_USE     = 3'd2,
    FN_RELEASE = 3'd3,
    FN_LOCK    = 3'd4,
    FN_UNLOCK  = 3'd5,
    FN_INIT    = 3'd6,
    FN_QUERY   = 3'd7
  } func_t;

  typedef enum logic {
    CS_IDLE,
    CS_RUN
  } ctl_state_t;

  // One item walking down the cell row, gathering per-pin results.
  typedef struct packed {
    logic              vld;
    func_t             func;
    logic [PIN_W-1:0]  pin;
    logic [MS_W-1:0]   elapsed;
    logic [MS_W-1:0]   timeout;
    logic              alow;
    logic              en;
    logic              changed;
    logic [WORD_W-1:0] word;
    logic              pen;
    logic [CNT_W-1:0]  pcnt;
  } wave_t;

  typedef struct packed {
    logic [WORD_W-1:0] shift_word;
    logic              shift_valid;
    logic              pin_enabled;
    logic [CNT_W-1:0]  pin_use_count;
    logic              new_power_flag;
  } res_t;

endpackage

FILE: rtl/psm_in_if.sv
// Input channel of the power switch manager.
`timescale 1ns / 1ps
interface psm_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [3:0]  pin_index;
  logic [15:0] elapsed_ms;
  logic [15:0] timeout_ms;
  logic        active_low;
  logic        enable_value;

  modport source (
    output valid, func, pin_index, elapsed_ms, timeout_ms, active_low, enable_value,
    input  ready
  );
  modport sink (
    input  valid, func, pin_index, elapsed_ms, timeout_ms, active_low, enable_value,
    output ready
  );
endinterface

FILE: rtl/psm_out_if.sv
// Result channel of the power switch manager.
`timescale 1ns / 1ps
interface psm_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] shift_word;
  logic        shift_valid;
  logic        pin_enabled;
  logic [7:0]  pin_use_count;
  logic        new_power_flag;

  modport source (
    output valid, shift_word, shift_valid, pin_enabled, pin_use_count, new_power_flag,
    input  ready
  );
  modport sink (
    input  valid, shift_word, shift_valid, pin_enabled, pin_use_count, new_power_flag,
    output ready
  );
endinterface

FILE: rtl/psm_cell.sv
// One pin cell: holds the state of one power switch and passes the item on.
`timescale 1ns / 1ps
module psm_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [psm_pkg::CELL_W-1:0] cell_id,
  input  psm_pkg::wave_t            wave_in,
  output psm_pkg::wave_t            wave_out
);

  logic                       req_r, req_nxt;
  logic                       act_r, act_nxt;
  logic                       inv_r, inv_nxt;
  logic                       lock_r, lock_nxt;
  logic [psm_pkg::MS_W-1:0]   timer_r, timer_nxt;
  logic [psm_pkg::MS_W-1:0]   tmo_r, tmo_nxt;
  logic [psm_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  psm_pkg::wave_t             wave_r, wave_nxt;

  logic                       hit;
  logic [psm_pkg::MS_W-1:0]   timer_dec;
  logic                       do_req;
  logic                       req_want;

  always_comb begin
    req_nxt   = req_r;
    act_nxt   = act_r;
    inv_nxt   = inv_r;
    lock_nxt  = lock_r;
    timer_nxt = timer_r;
    tmo_nxt   = tmo_r;
    cnt_nxt   = cnt_r;
    wave_nxt  = wave_in;
    do_req    = 1'b0;
    req_want  = req_r;
    hit       = (int'(cell_id) == int'(wave_in.pin));
    timer_dec = (timer_r > wave_in.elapsed) ? (timer_r - wave_in.elapsed) : '0;

    if (wave_in.vld) begin
      unique case (wave_in.func)
        psm_pkg::FN_TICK: begin
          timer_nxt = timer_dec;
          // switch once the hold-off has run out
          if ((req_r != act_r) && (timer_dec == '0)) begin
            act_nxt          = req_r;
            timer_nxt        = tmo_r;
            wave_nxt.changed = 1'b1;
          end
        end
        psm_pkg::FN_SET: begin
          if (hit) begin
            do_req   = 1'b1;
            req_want = wave_in.en;
          end
        end
        psm_pkg::FN_USE: begin
          if (hit) begin
            if (cnt_r != psm_pkg::CNT_MAX) begin
              cnt_nxt = cnt_r + 1'b1;
            end
            if (!lock_r) begin
              do_req   = 1'b1;
              req_want = 1'b1;
            end
          end
        end
        psm_pkg::FN_RELEASE: begin
          if (hit && (cnt_r != '0)) begin
            cnt_nxt = cnt_r - 1'b1;
            if (cnt_r == psm_pkg::CNT_W'(1)) begin
              do_req   = 1'b1;
              req_want = 1'b0;
            end
          end
        end
        psm_pkg::FN_LOCK: begin
          if (hit) begin
            lock_nxt = 1'b1;
            do_req   = 1'b1;
            req_want = 1'b0;
          end
        end
        psm_pkg::FN_UNLOCK: begin
          if (hit) begin
            lock_nxt = 1'b0;
            do_req   = 1'b1;
            req_want = (cnt_r != '0);
          end
        end
        psm_pkg::FN_INIT: begin
          if (hit) begin
            inv_nxt = wave_in.alow;
            tmo_nxt = wave_in.timeout;
          end
        end
        psm_pkg::FN_QUERY: begin
          if (hit) begin
            wave_nxt.pen  = act_r;
            wave_nxt.pcnt = cnt_r;
          end
        end
        default: ;
      endcase

      // a request back to the actual state cancels the pending switch
      if (do_req && (req_want != req_r)) begin
        req_nxt = req_want;
        if (req_want == act_r) begin
          timer_nxt = '0;
        end
      end
    end

    // each cell ORs its output level (actual state xor inversion) into its own bit of the word
    wave_nxt.word = wave_in.word
                  | (psm_pkg::WORD_W'(act_nxt ^ inv_nxt) << cell_id);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r      <= 1'b0;
      act_r      <= 1'b0;
      inv_r      <= 1'b0;
      lock_r     <= 1'b0;
      timer_r    <= '0;
      tmo_r      <= '0;
      cnt_r      <= '0;
      wave_r.vld <= 1'b0;
    end else begin
      req_r      <= req_nxt;
      act_r      <= act_nxt;
      inv_r      <= inv_nxt;
      lock_r     <= lock_nxt;
      timer_r    <= timer_nxt;
      tmo_r      <= tmo_nxt;
      cnt_r      <= cnt_nxt;
      wave_r.vld <= wave_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    wave_r.func    <= wave_nxt.func;
    wave_r.pin     <= wave_nxt.pin;
    wave_r.elapsed <= wave_nxt.elapsed;
    wave_r.timeout <= wave_nxt.timeout;
    wave_r.alow    <= wave_nxt.alow;
    wave_r.en      <= wave_nxt.en;
    wave_r.changed <= wave_nxt.changed;
    wave_r.word    <= wave_nxt.word;
    wave_r.pen     <= wave_nxt.pen;
    wave_r.pcnt    <= wave_nxt.pcnt;
  end

  assign wave_out = wave_r;

endmodule

FILE: rtl/power_switch_manager_core.sv
// Power switch manager: row of pin cells with a front-end controller and result buffer.
// The item walks the cell row, one cell per cycle; its result is then registered in the output buffer.
// Only one item is in the row at a time: a new item is accepted only after the last one has left it.
// A finished result waits in a two-deep output buffer while the next item is accepted.
// Reset (synchronous, active low) clears all pin state, new_power, and sets new_setting.
`timescale 1ns / 1ps
`include "power_switch_manager_core_macros.svh"
module power_switch_manager_core (
  input  logic        clk,
  input  logic        rst_n,
  psm_in_if.sink      in_chan,
  psm_out_if.source   out_chan
);

  psm_pkg::ctl_state_t state_r, state_nxt;
  psm_pkg::wave_t      waves [psm_pkg::PINS+1];
  psm_pkg::wave_t      exit_w;
  logic [psm_pkg::PINS-1:0] chain_vld;

  logic           in_acc;
  logic           in_rdy;
  logic           np_r, np_nxt;
  logic           ns_r, ns_nxt;
  logic           in_range;
  psm_pkg::res_t  res;
  psm_pkg::res_t  out_res_r, out_res_nxt;
  psm_pkg::res_t  pend_res_r, pend_res_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           pend_r, pend_nxt;
  logic           slot_free;

  assign in_acc          = in_chan.valid && in_rdy;
  assign in_chan.ready   = in_rdy;

  // launch the item into the first cell with empty gathered fields
  always_comb begin
    waves[0]         = '0;
    waves[0].vld     = in_acc;
    waves[0].func    = psm_pkg::func_t'(in_chan.func);
    waves[0].pin     = in_chan.pin_index;
    waves[0].elapsed = in_chan.elapsed_ms;
    waves[0].timeout = in_chan.timeout_ms;
    waves[0].alow    = in_chan.active_low;
    waves[0].en      = in_chan.enable_value;
  end

  for (genvar g = 0; g < psm_pkg::PINS; g++) begin : g_cell
    psm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_id  (psm_pkg::CELL_W'(g)),
      .wave_in  (waves[g]),
      .wave_out (waves[g+1])
    );
    assign chain_vld[g] = waves[g+1].vld;
  end

  assign exit_w = waves[psm_pkg::PINS];

  // controller state
  always_comb begin
    state_nxt = state_r;
    in_rdy    = 1'b0;
    unique case (state_r)
      psm_pkg::CS_IDLE: begin
        in_rdy = !pend_r;
        if (in_chan.valid && !pend_r) begin
          state_nxt = psm_pkg::CS_RUN;
        end
      end
      psm_pkg::CS_RUN: begin
        if (exit_w.vld) begin
          state_nxt = psm_pkg::CS_IDLE;
        end
      end
      default: state_nxt = psm_pkg::CS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= psm_pkg::CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // form the result and update the global flags when the item leaves the row
  always_comb begin
    res      = '0;
    np_nxt   = np_r;
    ns_nxt   = ns_r;
    in_range = (int'(exit_w.pin) < psm_pkg::PINS);
    if (exit_w.vld) begin
      unique case (exit_w.func)
        psm_pkg::FN_TICK: begin
          if (exit_w.changed) begin
            np_nxt = 1'b1;
          end
          if (exit_w.changed || ns_r) begin
            res.shift_word  = exit_w.word;
            res.shift_valid = 1'b1;
            ns_nxt          = 1'b0;
          end
        end
        psm_pkg::FN_QUERY: begin
          res.pin_enabled    = exit_w.pen;
          res.pin_use_count  = exit_w.pcnt;
          res.new_power_flag = np_r;
          np_nxt             = 1'b0;
        end
        psm_pkg::FN_USE, psm_pkg::FN_RELEASE: begin
          if (in_range) begin
            np_nxt = 1'b1;
          end
        end
        psm_pkg::FN_INIT: begin
          if (in_range) begin
            ns_nxt = 1'b1;
          end
        end
        psm_pkg::FN_SET, psm_pkg::FN_LOCK, psm_pkg::FN_UNLOCK: ;
        default: ;
      endcase
    end
  end

  // output register plus one pending slot
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    pend_nxt      = pend_r;
    pend_res_nxt  = pend_res_r;
    slot_free     = !out_valid_r || out_chan.ready;
    if (slot_free) begin
      if (pend_r) begin
        out_valid_nxt = 1'b1;
        out_res_nxt   = pend_res_r;
        pend_nxt      = 1'b0;
      end else if (exit_w.vld) begin
        out_valid_nxt = 1'b1;
        out_res_nxt   = res;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (exit_w.vld) begin
      pend_nxt     = 1'b1;
      pend_res_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      np_r        <= 1'b0;
      ns_r        <= 1'b1;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      np_r        <= np_nxt;
      ns_r        <= ns_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    pend_res_r <= pend_res_nxt;
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.shift_word     = out_res_r.shift_word;
  assign out_chan.shift_valid    = out_res_r.shift_valid;
  assign out_chan.pin_enabled    = out_res_r.pin_enabled;
  assign out_chan.pin_use_count  = out_res_r.pin_use_count;
  assign out_chan.new_power_flag = out_res_r.new_power_flag;

  `PSM_ASSERT(a_one_item_in_row, (state_r == psm_pkg::CS_RUN) |-> $onehot(chain_vld))
  `PSM_ASSERT(a_row_empty_idle, (state_r == psm_pkg::CS_IDLE) |-> (chain_vld == '0))
  `PSM_ASSERT(a_exit_no_pend, exit_w.vld |-> !pend_r)
  `PSM_ASSERT(a_pend_behind_out, pend_r |-> out_valid_r)
  `PSM_ASSERT_ANY(a_reset_clears, $past(!rst_n) |-> (!out_valid_r && !pend_r && ns_r))

endmodule

FILE: tb/power_switch_manager_core_test.sv
// Self-checking testbench for the power switch manager core.
`timescale 1ns / 1ps
module power_switch_manager_core_test;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 3 * (psm_pkg::PINS + 1);
  localparam int PRINT_LIMIT  = 20;

  typedef struct {
    psm_pkg::func_t                func;
    logic [psm_pkg::PIN_W-1:0]     pin;
    logic [psm_pkg::MS_W-1:0]      elapsed;
    logic [psm_pkg::MS_W-1:0]      timeout;
    logic                          alow;
    logic                          en;
  } switch_op_t;

  logic clk;
  logic rst_n;

  psm_in_if  in_chan ();
  psm_out_if out_chan ();

  power_switch_manager_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Predicted pin state
  logic [psm_pkg::WORD_W-1:0] req_mask;
  logic [psm_pkg::WORD_W-1:0] act_mask;
  logic [psm_pkg::WORD_W-1:0] inv_mask;
  logic [psm_pkg::WORD_W-1:0] lock_mask;
  logic [psm_pkg::MS_W-1:0]   hold_left [psm_pkg::PINS];
  logic [psm_pkg::MS_W-1:0]   hold_time [psm_pkg::PINS];
  logic [psm_pkg::CNT_W-1:0]  use_cnt [psm_pkg::PINS];
  logic                       new_power;
  logic                       new_setting;

  psm_pkg::res_t pending_results[$];
  psm_pkg::res_t want_result;

  int src_idle_pct    = 0;
  int sink_idle_pct   = 0;
  int errors          = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int words_shifted   = 0;
  int cycles          = 0;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic void request_pin(int p, logic en);
    if (en == req_mask[p]) return;
    req_mask[p] = en;
    // request back to the actual state: cancel the pending switch
    if (en == act_mask[p]) hold_left[p] = '0;
  endfunction

  function automatic psm_pkg::res_t predict_switches(switch_op_t op);
    psm_pkg::res_t r;
    logic changed;
    int   p;
    r       = '0;
    changed = 1'b0;
    p       = int'(op.pin);
    case (op.func)
      psm_pkg::FN_TICK: begin
        for (int i = 0; i < psm_pkg::PINS; i++) begin
          hold_left[i] = (hold_left[i] > op.elapsed) ? hold_left[i] - op.elapsed : '0;
          if (req_mask[i] != act_mask[i] && hold_left[i] == '0) begin
            new_power    = 1'b1;
            act_mask[i]  = req_mask[i];
            hold_left[i] = hold_time[i];
            changed      = 1'b1;
          end
        end
        if (changed || new_setting) begin
          r.shift_word  = act_mask ^ inv_mask;
          r.shift_valid = 1'b1;
          new_setting   = 1'b0;
        end
      end
      psm_pkg::FN_SET: request_pin(p, op.en);
      psm_pkg::FN_USE: begin
        new_power = 1'b1;
        if (use_cnt[p] != psm_pkg::CNT_MAX) use_cnt[p] = use_cnt[p] + 1'b1;
        if (!lock_mask[p]) request_pin(p, 1'b1);
      end
      psm_pkg::FN_RELEASE: begin
        new_power = 1'b1;
        if (use_cnt[p] != '0) begin
          use_cnt[p] = use_cnt[p] - 1'b1;
          if (use_cnt[p] == '0) request_pin(p, 1'b0);
        end
      end
      psm_pkg::FN_LOCK: begin
        lock_mask[p] = 1'b1;
        request_pin(p, 1'b0);
      end
      psm_pkg::FN_UNLOCK: begin
        lock_mask[p] = 1'b0;
        request_pin(p, use_cnt[p] != '0);
      end
      psm_pkg::FN_INIT: begin
        inv_mask[p]  = op.alow;
        hold_time[p] = op.timeout;
        new_setting  = 1'b1;
      end
      psm_pkg::FN_QUERY: begin
        r.pin_enabled    = act_mask[p];
        r.pin_use_count  = use_cnt[p];
        r.new_power_flag = new_power;
        new_power        = 1'b0;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic switch_op_t make_op(psm_pkg::func_t f, int pin, int elapsed,
                                         int timeout, bit alow, bit en);
    switch_op_t op;
    op.func    = f;
    op.pin     = psm_pkg::PIN_W'(pin);
    op.elapsed = psm_pkg::MS_W'(elapsed);
    op.timeout = psm_pkg::MS_W'(timeout);
    op.alow    = alow;
    op.en      = en;
    return op;
  endfunction

  task automatic send_op(switch_op_t op);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid        <= 1'b1;
    in_chan.func         <= op.func;
    in_chan.pin_index    <= op.pin;
    in_chan.elapsed_ms   <= op.elapsed;
    in_chan.timeout_ms   <= op.timeout;
    in_chan.active_low   <= op.alow;
    in_chan.enable_value <= op.en;
    do @(posedge clk); while (!in_chan.ready);
    pending_results.push_back(predict_switches(op));
    items_sent++;
  endtask

  task automatic hold_sender();
    @(negedge clk);
    in_chan.valid <= 1'b0;
  endtask

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    errors++;
    if (errors <= PRINT_LIMIT)
      $display("[%0t] result %0d: %s got %0h, expected %0h",
               $time, results_checked, what, got, want);
  endtask

  task automatic test_power_up_and_switching();
    send_op(make_op(psm_pkg::FN_TICK,    0,     0,     0, 0, 0)); // first tick always emits
    send_op(make_op(psm_pkg::FN_QUERY,   0,     0,     0, 0, 0));
    send_op(make_op(psm_pkg::FN_INIT,    0,     0,     0, 1, 0));
    send_op(make_op(psm_pkg::FN_INIT,   15,     0, 65535, 0, 0));
    send_op(make_op(psm_pkg::FN_TICK,    0,     0,     0, 0, 0));
    send_op(make_op(psm_pkg::FN_USE,     0,     0,     0, 0, 0));
    send_op(make_op(psm_pkg::FN_SET,     0,     0,     0, 0, 1)); // already requested
    send_op(make_op(psm_pkg::FN_TICK,    0,     1,     0, 0, 0));
    send_op(make_op(psm_pkg::FN_USE,    15,     0,     0, 0, 0));
    send_op(make_op(psm_pkg::FN_TICK,    0, 65535,     0, 0, 0));
    send_op(make_op(psm_pkg::FN_RELEASE,15,     0,     0, 0, 0)); // switch-off now held off
    send_op(make_op(psm_pkg::FN_TICK,    0,   100,     0, 0, 0));
    send_op(make_op(psm_pkg::FN_SET,    15,     0,     0, 0, 1)); // cancel the pending switch
    send_op(make_op(psm_pkg::FN_TICK,    0,     0,     0, 0, 0));
    send_op(make_op(psm_pkg::FN_RELEASE,15,     0,     0, 0, 0)); // count already zero
    send_op(make_op(psm_pkg::FN_LOCK,    0,     0,     0, 0, 0));
    send_op(make_op(psm_pkg::FN_TICK,    0,     0,     0, 0, 0));
    send_op(make_op(psm_pkg::FN_USE,     0,     0,     0, 0, 0)); // locked: request stays off
    send_op(make_op(psm_pkg::FN_UNLOCK,  0,     0,     0, 0, 0));
    send_op(make_op(psm_pkg::FN_SET,     0,     0,     0, 0, 0));
    send_op(make_op(psm_pkg::FN_QUERY,   0,     0,     0, 0, 0));
    send_op(make_op(psm_pkg::FN_QUERY,   0,     0,     0, 0, 0)); // flag cleared by last query
    send_op(make_op(psm_pkg::FN_INIT,    5,     0, 16'h5aa5, 1, 1));
    send_op(make_op(psm_pkg::FN_TICK,    0, 65535,     0, 0, 0));
    send_op(make_op(psm_pkg::FN_QUERY,  15,     0,     0, 0, 0));
  endtask

  task automatic test_use_saturation();
    send_op(make_op(psm_pkg::FN_INIT, 9, 0, 3, 0, 0));
    repeat (int'(psm_pkg::CNT_MAX) + 2) send_op(make_op(psm_pkg::FN_USE, 9, 0, 0, 0, 0));
    send_op(make_op(psm_pkg::FN_QUERY,   9, 0, 0, 0, 0));
    send_op(make_op(psm_pkg::FN_RELEASE, 9, 0, 0, 0, 0));
    send_op(make_op(psm_pkg::FN_TICK,    0, 2, 0, 0, 0));
    send_op(make_op(psm_pkg::FN_QUERY,   9, 0, 0, 0, 0));
  endtask

  task automatic test_random_traffic(int count, bit drain_midway);
    switch_op_t op;
    int         roll;
    for (int n = 0; n < count; n++) begin
      if (drain_midway && n == count / 2) begin
        hold_sender();
        wait (pending_results.size() == 0);
      end
      roll = $urandom_range(99);
      if (roll < 30)      op.func = psm_pkg::FN_TICK;
      else if (roll < 50) op.func = psm_pkg::FN_USE;
      else if (roll < 63) op.func = psm_pkg::FN_RELEASE;
      else if (roll < 70) op.func = psm_pkg::FN_SET;
      else if (roll < 75) op.func = psm_pkg::FN_LOCK;
      else if (roll < 80) op.func = psm_pkg::FN_UNLOCK;
      else if (roll < 87) op.func = psm_pkg::FN_INIT;
      else                op.func = psm_pkg::FN_QUERY;
      // crowd most traffic onto a few pins so counts and timers build up
      op.pin = psm_pkg::PIN_W'(($urandom_range(99) < 70) ? $urandom_range(3)
                                                         : $urandom_range(15));
      roll = $urandom_range(99);
      if (roll < 80)      op.elapsed = psm_pkg::MS_W'($urandom_range(20));
      else if (roll < 95) op.elapsed = psm_pkg::MS_W'($urandom_range(500));
      else                op.elapsed = psm_pkg::MS_W'($urandom_range(65535));
      roll = $urandom_range(99);
      if (roll < 70)      op.timeout = psm_pkg::MS_W'($urandom_range(40));
      else if (roll < 95) op.timeout = psm_pkg::MS_W'($urandom_range(1000));
      else                op.timeout = psm_pkg::MS_W'($urandom_range(65535));
      op.alow = 1'($urandom_range(1));
      op.en   = 1'($urandom_range(1));
      send_op(op);
    end
  endtask

  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_chan.ready <= rst_n && ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", 32'(out_chan.shift_word), 0);
      end else begin
        want_result = pending_results.pop_front();
        if (out_chan.shift_word !== want_result.shift_word)
          report_mismatch("shift_word", 32'(out_chan.shift_word),
                          32'(want_result.shift_word));
        if (out_chan.shift_valid !== want_result.shift_valid)
          report_mismatch("shift_valid", 32'(out_chan.shift_valid),
                          32'(want_result.shift_valid));
        if (out_chan.pin_enabled !== want_result.pin_enabled)
          report_mismatch("pin_enabled", 32'(out_chan.pin_enabled),
                          32'(want_result.pin_enabled));
        if (out_chan.pin_use_count !== want_result.pin_use_count)
          report_mismatch("pin_use_count", 32'(out_chan.pin_use_count),
                          32'(want_result.pin_use_count));
        if (out_chan.new_power_flag !== want_result.new_power_flag)
          report_mismatch("new_power_flag", 32'(out_chan.new_power_flag),
                          32'(want_result.new_power_flag));
        if (want_result.shift_valid) words_shifted++;
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("watchdog expired after %0d cycles, %0d results still pending",
               cycles, pending_results.size());
      $display("power_switch_manager_core: mismatch");
      $finish;
    end
  end

  initial begin
    rst_n                = 1'b0;
    in_chan.valid        = 1'b0;
    in_chan.func         = psm_pkg::FN_TICK;
    in_chan.pin_index    = '0;
    in_chan.elapsed_ms   = '0;
    in_chan.timeout_ms   = '0;
    in_chan.active_low   = 1'b0;
    in_chan.enable_value = 1'b0;
    req_mask    = '0;
    act_mask    = '0;
    inv_mask    = '0;
    lock_mask   = '0;
    new_power   = 1'b0;
    new_setting = 1'b1;
    for (int i = 0; i < psm_pkg::PINS; i++) begin
      hold_left[i] = '0;
      hold_time[i] = '0;
      use_cnt[i]   = '0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    src_idle_pct  = 6;
    sink_idle_pct = 69;
    test_power_up_and_switching();
    test_use_saturation();

    src_idle_pct  = 69;
    sink_idle_pct = 6;
    test_random_traffic(220, 1'b0);

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_random_traffic(220, 1'b1);

    hold_sender();
    wait (pending_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d items, checked %0d results, %0d of them shift words",
             items_sent, results_checked, words_shifted);
    $display("covered hold-off, cancel, lock, saturation and random traffic under stalls");
    if (errors == 0) begin
      $display("power_switch_manager_core: match");
    end else begin
      $display("power_switch_manager_core: mismatch");
    end
    $finish;
  end

endmodule

FILE: power_switch_manager_core.f
+incdir+rtl
rtl/psm_pkg.sv
rtl/psm_in_if.sv
rtl/psm_out_if.sv
rtl/psm_cell.sv
rtl/power_switch_manager_core.sv
tb/power_switch_manager_core_test.sv
